>>> hw/rtl/ertj_pkg.sv
// Shared constants, types and helpers for the Euler rotation block.
`default_nettype none
package ertj_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int ANG_W     = 25;

  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  // pi/180 in Q32
  localparam logic signed [31:0] RAD_K   = 32'sd74961321;

  // Angle landmarks in Q16 degrees
  localparam logic [24:0] DEG45    = 25'd2949120;
  localparam logic [24:0] DEG90    = 25'd5898240;
  localparam logic [24:0] DEG180   = 25'd11796480;
  localparam logic [24:0] DEG270   = 25'd17694720;
  localparam logic [25:0] DEG360   = 26'd23592960;

  // Matrix build sequence
  localparam logic [4:0] MSTEP_LAST = 5'd19;
  localparam logic [2:0] TERM_LAST  = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  // Degree-of-freedom codes
  localparam logic [2:0] DOF_TX = 3'd0;
  localparam logic [2:0] DOF_TY = 3'd1;
  localparam logic [2:0] DOF_TZ = 3'd2;
  localparam logic [2:0] DOF_RX = 3'd3;
  localparam logic [2:0] DOF_RY = 3'd4;
  localparam logic [2:0] DOF_RZ = 3'd5;

  // Rotation matrix plus the extra terms for the derivative matrices (Q30)
  typedef struct packed {
    logic signed [31:0] r00, r01, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] sy, cy, sxsy, cxsy;
    logic signed [31:0] d00, d01, d10, d11, d20, d21;
  } mat_t;

  // Round half up, Q60 product back to Q30
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  // Factorial ratios of the sine series
  function automatic logic [7:0] sin_div(input logic [2:0] k);
    case (k)
      3'd1:    return 8'd6;
      3'd2:    return 8'd20;
      3'd3:    return 8'd42;
      3'd4:    return 8'd72;
      3'd5:    return 8'd110;
      3'd6:    return 8'd156;
      default: return 8'd1;
    endcase
  endfunction

  // Factorial ratios of the cosine series
  function automatic logic [7:0] cos_div(input logic [2:0] k);
    case (k)
      3'd1:    return 8'd2;
      3'd2:    return 8'd12;
      3'd3:    return 8'd30;
      3'd4:    return 8'd56;
      3'd5:    return 8'd90;
      3'd6:    return 8'd132;
      default: return 8'd1;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ertj_div.sv
// Reciprocal-multiply divider by the series factorial ratios, quotient in the cycle after start.
`default_nettype none
module ertj_div
  import ertj_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [30:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [30:0]      quotient
);

  logic [31:0] recip;
  logic [5:0]  shamt;
  logic [63:0] prod;
  logic [5:0]  prod_sh;

  // recip = ceil(2^shamt / d) with 2^shamt / d in [2^30, 2^31);
  // the floored quotient is exact for every dividend below 2^30
  always_comb begin
    case (divisor)
      8'd2:    begin recip = 32'd1073741824; shamt = 6'd31; end
      8'd6:    begin recip = 32'd1431655766; shamt = 6'd33; end
      8'd12:   begin recip = 32'd1431655766; shamt = 6'd34; end
      8'd20:   begin recip = 32'd1717986919; shamt = 6'd35; end
      8'd30:   begin recip = 32'd1145324613; shamt = 6'd35; end
      8'd42:   begin recip = 32'd1636178018; shamt = 6'd36; end
      8'd56:   begin recip = 32'd1227133514; shamt = 6'd36; end
      8'd72:   begin recip = 32'd1908874354; shamt = 6'd37; end
      8'd90:   begin recip = 32'd1527099484; shamt = 6'd37; end
      8'd110:  begin recip = 32'd1249445032; shamt = 6'd37; end
      8'd132:  begin recip = 32'd2082408386; shamt = 6'd38; end
      8'd156:  begin recip = 32'd1762037866; shamt = 6'd38; end
      default: begin recip = 32'd1073741824; shamt = 6'd30; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Datapath: one product per start, shifted down on the way out
  always_ff @(posedge clk) begin
    if (start) begin
      prod    <= {33'd0, dividend} * {32'd0, recip};
      prod_sh <= shamt;
    end
  end

  assign quotient = 31'(prod >> prod_sh);

endmodule
`default_nettype wire

>>> hw/rtl/ertj_trig.sv
// Angle registers and sequencer that builds the rotation matrix terms.
`default_nettype none
module ertj_trig
  import ertj_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ANG_W-1:0]  cfg_data,
  output logic                   busy,
  output mat_t                   mat
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_RED  = 15'b000000000000010,
    ST_XM   = 15'b000000000000100,
    ST_XR   = 15'b000000000001000,
    ST_X2M  = 15'b000000000010000,
    ST_X2R  = 15'b000000000100000,
    ST_TSM  = 15'b000000001000000,
    ST_TSS  = 15'b000000010000000,
    ST_TSD  = 15'b000000100000000,
    ST_TCM  = 15'b000001000000000,
    ST_TCS  = 15'b000010000000000,
    ST_TCD  = 15'b000100000000000,
    ST_FIN  = 15'b001000000000000,
    ST_MI   = 15'b010000000000000,
    ST_MW   = 15'b100000000000000
  } state_t;

  state_t state;
  logic signed [ANG_W-1:0] angle_x, angle_y, angle_z;
  logic [1:0]  ang_sel;
  logic [22:0] t_fold;
  logic [1:0]  quad;
  logic        swap;
  logic [2:0]  k;
  logic [4:0]  mstep;
  logic signed [31:0] x, x2, ts, ss, tc, sc;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0] sxsy, cxsy, r00, r01, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] tmp_a, tmp_b, tmp_c, tmp_d;
  logic signed [31:0] d00, d01, d10, d11, d20, d21;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;

  // Angle reduction wires
  logic signed [ANG_W-1:0] ang;
  logic [25:0] red_sum;
  logic [24:0] red;
  logic [24:0] base;
  logic [1:0]  quad_c;
  logic [24:0] f;
  logic signed [63:0] x_full;
  logic signed [31:0] w;
  logic signed [31:0] s0, c0, s_q, c_q;
  logic               div_start, div_done;
  logic [30:0]        div_dividend, quot;
  logic [7:0]         div_divisor;
  logic signed [31:0] quot_s;

  // Configuration writes restart the build
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_X: angle_x <= $signed(cfg_data);
        REG_ANGLE_Y: angle_y <= $signed(cfg_data);
        REG_ANGLE_Z: angle_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Reduce to 0..360 then to a quadrant and the angle within it
  always_comb begin
    case (ang_sel)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    red_sum = {ang[ANG_W-1], ang} + DEG360;
    red     = ang[ANG_W-1] ? red_sum[24:0] : ang;
    if (red >= DEG270) begin
      quad_c = 2'd3; base = DEG270;
    end else if (red >= DEG180) begin
      quad_c = 2'd2; base = DEG180;
    end else if (red >= DEG90) begin
      quad_c = 2'd1; base = DEG90;
    end else begin
      quad_c = 2'd0; base = '0;
    end
    f = red - base;
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_XM: begin
        mul_a = $signed({9'd0, t_fold});
        mul_b = RAD_K;
      end
      ST_X2M: begin
        mul_a = x; mul_b = x;
      end
      ST_TSM: begin
        mul_a = ts; mul_b = x2;
      end
      ST_TCM: begin
        mul_a = tc; mul_b = x2;
      end
      ST_MI: begin
        case (mstep)
          5'd0:    begin mul_a = sx;   mul_b = sy; end
          5'd1:    begin mul_a = cx;   mul_b = sy; end
          5'd2:    begin mul_a = cy;   mul_b = cz; end
          5'd3:    begin mul_a = cy;   mul_b = sz; end
          5'd4:    begin mul_a = sx;   mul_b = cy; end
          5'd5:    begin mul_a = cx;   mul_b = cy; end
          5'd6:    begin mul_a = cx;   mul_b = sz; end
          5'd7:    begin mul_a = cx;   mul_b = cz; end
          5'd8:    begin mul_a = sx;   mul_b = sz; end
          5'd9:    begin mul_a = sx;   mul_b = cz; end
          5'd10:   begin mul_a = sxsy; mul_b = cz; end
          5'd11:   begin mul_a = sxsy; mul_b = sz; end
          5'd12:   begin mul_a = cxsy; mul_b = cz; end
          5'd13:   begin mul_a = cxsy; mul_b = sz; end
          5'd14:   begin mul_a = sy;   mul_b = cz; end
          5'd15:   begin mul_a = sy;   mul_b = sz; end
          5'd16:   begin mul_a = r12;  mul_b = cz; end
          5'd17:   begin mul_a = r12;  mul_b = sz; end
          5'd18:   begin mul_a = r22;  mul_b = cz; end
          default: begin mul_a = r22;  mul_b = sz; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign x_full = (prod + 64'sd131072) >>> 18;
  assign w      = 32'(rnd30(prod));
  assign quot_s = $signed({1'b0, quot});

  // Series divider
  assign div_start    = (state == ST_TSS) || (state == ST_TCS);
  assign div_dividend = 31'(rnd30(prod));
  assign div_divisor  = (state == ST_TSS) ? sin_div(k) : cos_div(k);

  ertj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // Octant result to full-circle sine and cosine
  always_comb begin
    s0 = swap ? sc : ss;
    c0 = swap ? ss : sc;
    case (quad)
      2'd0:    begin s_q = s0;  c_q = c0;  end
      2'd1:    begin s_q = c0;  c_q = -s0; end
      2'd2:    begin s_q = -s0; c_q = -c0; end
      default: begin s_q = -c0; c_q = s0;  end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RED;
      ang_sel <= '0;
      k       <= '0;
      mstep   <= '0;
    end else if (cfg_valid) begin
      state   <= ST_RED;
      ang_sel <= '0;
    end else begin
      case (state)
        ST_IDLE: ;
        ST_RED:  state <= ST_XM;
        ST_XM:   state <= ST_XR;
        ST_XR:   state <= ST_X2M;
        ST_X2M:  state <= ST_X2R;
        ST_X2R: begin
          k     <= 3'd1;
          state <= ST_TSM;
        end
        ST_TSM:  state <= ST_TSS;
        ST_TSS:  state <= ST_TSD;
        ST_TSD:  if (div_done) state <= ST_TCM;
        ST_TCM:  state <= ST_TCS;
        ST_TCS:  state <= ST_TCD;
        ST_TCD: begin
          if (div_done) begin
            if (k == TERM_LAST) begin
              state <= ST_FIN;
            end else begin
              k     <= k + 3'd1;
              state <= ST_TSM;
            end
          end
        end
        ST_FIN: begin
          if (ang_sel == 2'd2) begin
            mstep <= '0;
            state <= ST_MI;
          end else begin
            ang_sel <= ang_sel + 2'd1;
            state   <= ST_RED;
          end
        end
        ST_MI:   state <= ST_MW;
        ST_MW: begin
          if (mstep == MSTEP_LAST) begin
            state <= ST_IDLE;
          end else begin
            mstep <= mstep + 5'd1;
            state <= ST_MI;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_RED: begin
        quad <= quad_c;
        if (f > DEG45) begin
          t_fold <= 23'(DEG90 - f);
          swap   <= 1'b1;
        end else begin
          t_fold <= f[22:0];
          swap   <= 1'b0;
        end
      end
      ST_XR:  x <= x_full[31:0];
      ST_X2R: begin
        x2 <= w;
        ts <= x;
        ss <= x;
        tc <= Q30_ONE;
        sc <= Q30_ONE;
      end
      ST_TSD: begin
        if (div_done) begin
          ts <= quot_s;
          ss <= k[0] ? ss - quot_s : ss + quot_s;
        end
      end
      ST_TCD: begin
        if (div_done) begin
          tc <= quot_s;
          sc <= k[0] ? sc - quot_s : sc + quot_s;
        end
      end
      ST_FIN: begin
        case (ang_sel)
          2'd0:    begin sx <= s_q; cx <= c_q; end
          2'd1:    begin sy <= s_q; cy <= c_q; end
          default: begin sz <= s_q; cz <= c_q; end
        endcase
      end
      ST_MW: begin
        case (mstep)
          5'd0:    sxsy  <= w;
          5'd1:    cxsy  <= w;
          5'd2:    r00   <= w;
          5'd3:    r01   <= w;
          5'd4:    r12   <= w;
          5'd5:    r22   <= w;
          5'd6:    tmp_a <= w;
          5'd7:    tmp_b <= w;
          5'd8:    tmp_c <= w;
          5'd9:    tmp_d <= w;
          5'd10:   r10   <= w - tmp_a;
          5'd11:   r11   <= w + tmp_b;
          5'd12:   r20   <= w + tmp_c;
          5'd13:   r21   <= w - tmp_d;
          5'd14:   d00   <= -w;
          5'd15:   d01   <= -w;
          5'd16:   d10   <= w;
          5'd17:   d11   <= w;
          5'd18:   d20   <= w;
          default: d21   <= w;
        endcase
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    mat.r00  = r00;  mat.r01  = r01;  mat.r10 = r10;  mat.r11 = r11;
    mat.r12  = r12;  mat.r20  = r20;  mat.r21 = r21;  mat.r22 = r22;
    mat.sy   = sy;   mat.cy   = cy;   mat.sxsy = sxsy; mat.cxsy = cxsy;
    mat.d00  = d00;  mat.d01  = d01;  mat.d10 = d10;
    mat.d11  = d11;  mat.d20  = d20;  mat.d21 = d21;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ertj_pipe.sv
// Three-stage point pipeline: matrix select, products, row sums.
`default_nettype none
module ertj_pipe
  import ertj_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  mat_t                    mat,
  input  wire logic               hold,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [2:0]         dof_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result_x,
  output logic signed [31:0]      result_y,
  output logic signed [31:0]      result_z,
  output logic                    bad_dof
);

  logic va, vb;
  logic adv_a, adv_b, adv_c;
  logic signed [31:0] msel [9];
  logic signed [31:0] qsel [3];
  logic signed [31:0] p_in [3];
  logic signed [31:0] ma [9];
  logic signed [31:0] qa [3];
  logic signed [49:0] tb [9];
  logic bad_a, trans_a, bad_b, trans_b;
  logic [1:0] axis_a, axis_b;
  logic signed [51:0] rsum [3];
  logic signed [51:0] rrnd [3];
  logic signed [31:0] rsat [3];
  logic signed [31:0] rout [3];
  logic signed [63:0] qprod [3];
  logic signed [63:0] tprod [9];

  // Transfer control: each stage moves when the next one has room
  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !vb || adv_c;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid && in_ready;
      if (adv_b) vb <= va;
      if (adv_c) out_valid <= vb;
    end
  end

  // Stage A: pick the matrix and scale the point
  assign p_in[0] = point_x;
  assign p_in[1] = point_y;
  assign p_in[2] = point_z;

  always_comb begin
    for (int i = 0; i < 9; i++) msel[i] = '0;
    if (!kind) begin
      msel[0] = mat.r00; msel[1] = mat.r01; msel[2] = -mat.sy;
      msel[3] = mat.r10; msel[4] = mat.r11; msel[5] = mat.r12;
      msel[6] = mat.r20; msel[7] = mat.r21; msel[8] = mat.r22;
    end else begin
      case (dof_index)
        DOF_RX: begin
          msel[3] = mat.r20;  msel[4] = mat.r21;  msel[5] = mat.r22;
          msel[6] = -mat.r10; msel[7] = -mat.r11; msel[8] = -mat.r12;
        end
        DOF_RY: begin
          msel[0] = mat.d00; msel[1] = mat.d01; msel[2] = -mat.cy;
          msel[3] = mat.d10; msel[4] = mat.d11; msel[5] = -mat.sxsy;
          msel[6] = mat.d20; msel[7] = mat.d21; msel[8] = -mat.cxsy;
        end
        DOF_RZ: begin
          msel[0] = -mat.r01; msel[1] = mat.r00;
          msel[3] = -mat.r11; msel[4] = mat.r10;
          msel[6] = -mat.r21; msel[7] = mat.r20;
        end
        default: ;
      endcase
    end
    for (int j = 0; j < 3; j++) begin
      qprod[j] = (p_in[j] * RAD_K + 64'sd2147483648) >>> 32;
      qsel[j]  = kind ? qprod[j][31:0] : p_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int i = 0; i < 9; i++) ma[i] <= msel[i];
      for (int j = 0; j < 3; j++) qa[j] <= qsel[j];
      bad_a   <= kind && (dof_index > DOF_RZ);
      trans_a <= kind && (dof_index < DOF_RX);
      axis_a  <= dof_index[1:0];
    end
  end

  // Stage B: nine Q46 products, floored to Q32 terms
  always_comb begin
    for (int i = 0; i < 9; i++) tprod[i] = ma[i] * qa[i % 3];
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      for (int i = 0; i < 9; i++) tb[i] <= tprod[i][63:14];
      bad_b   <= bad_a;
      trans_b <= trans_a;
      axis_b  <= axis_a;
    end
  end

  // Stage C: row sums, rounding, saturation, special results
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = 52'(tb[3*r]) + 52'(tb[3*r+1]) + 52'(tb[3*r+2]);
      rrnd[r] = (rsum[r] + 52'sd32768) >>> 16;
      if (rrnd[r] > 52'sd2147483647)
        rsat[r] = 32'sh7fffffff;
      else if (rrnd[r] < -52'sd2147483648)
        rsat[r] = 32'sh80000000;
      else
        rsat[r] = rrnd[r][31:0];
      if (bad_b)
        rout[r] = '0;
      else if (trans_b)
        rout[r] = (axis_b == 2'(r)) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      else
        rout[r] = rsat[r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      result_x <= rout[0];
      result_y <= rout[1];
      result_z <= rout[2];
      bad_dof  <= bad_b;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/euler_rotate_point_and_jacobian.sv
// Registered stages A, B, C; one point per cycle unless out_ready or a rebuild stalls it.
// Results sit in the last stage register; earlier stages keep filling while it waits.
// Reset (synchronous, active high) clears the angles to zero and empties the pipeline.
// After reset and after every angle write the trig sequencer rebuilds the matrix with one
// shared multiplier and a reciprocal divider; in_ready is low meanwhile.
`default_nettype none
module euler_rotate_point_and_jacobian
  import ertj_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [ANG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [2:0]         dof_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result_x,
  output logic signed [31:0]      result_y,
  output logic signed [31:0]      result_z,
  output logic                    bad_dof
);

  mat_t mat;
  logic busy;

  assign cfg_ready = 1'b1;

  ertj_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .mat       (mat)
  );

  ertj_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .mat       (mat),
    .hold      (busy),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .dof_index (dof_index),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_x  (result_x),
    .result_y  (result_y),
    .result_z  (result_z),
    .bad_dof   (bad_dof)
  );

endmodule
`default_nettype wire

>>> tb/euler_rotate_point_and_jacobian_tb.sv
// Testbench for the Euler rotation and derivative block: predictor, driver, monitor.
`timescale 1ns / 100ps
module euler_rotate_point_and_jacobian_tb;
  import ertj_pkg::*;

  localparam int N_RANDOM = 1040;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        kind;
    logic [2:0]  dof;
    logic signed [31:0] px, py, pz;
  } point_item_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic        bad;
  } point_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [ANG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [2:0] dof_index = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_x, result_y, result_z;
  logic bad_dof;

  euler_rotate_point_and_jacobian i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .dof_index(dof_index),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_x(result_x), .result_y(result_y), .result_z(result_z),
    .bad_dof(bad_dof)
  );

  always #1 clk = ~clk;

  // Predictor copy of the angle registers
  longint ang_x = 0, ang_y = 0, ang_z = 0;

  point_item_t   pending_points[$];
  point_result_t expected_results[$];
  int  errors = 0;
  int  n_results = 0;
  int  n_deriv = 0;
  longint cycle = 0;
  logic driving = 1'b0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  // Taylor sine/cosine over 0..45 degrees
  task automatic octant_trig(input longint t, output longint s, output longint c);
    longint x, x2, ts, tc;
    s = 0;
    x = round_shift(t * longint'(RAD_K), 18);
    x2 = round_shift(x * x, 30);
    ts = x; s = x; tc = longint'(Q30_ONE); c = tc;
    for (int k = 1; k <= 6; k++) begin
      ts = round_shift(ts * x2, 30) / ((2 * k) * (2 * k + 1));
      tc = round_shift(tc * x2, 30) / ((2 * k - 1) * (2 * k));
      if (k & 1) begin
        s -= ts; c -= tc;
      end else begin
        s += ts; c += tc;
      end
    end
  endtask

  task automatic angle_trig(input longint a, output longint s, output longint c);
    longint full, quarter, r, q, f, s0, c0;
    full = 360 * 65536;
    quarter = 90 * 65536;
    r = a % full;
    if (r < 0) r += full;
    q = r / quarter;
    f = r - q * quarter;
    if (f <= 45 * 65536) octant_trig(f, s0, c0);
    else octant_trig(quarter - f, c0, s0);
    case (q)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  function automatic logic signed [31:0] row_dot(longint m0, longint m1, longint m2,
                                                 longint p0, longint p1, longint p2);
    longint acc;
    acc = ((m0 * p0) >>> 14) + ((m1 * p1) >>> 14) + ((m2 * p2) >>> 14);
    acc = round_shift(acc, 16);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  task automatic predict_point(input point_item_t it, output point_result_t res);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    longint m[3][3];
    longint q[3];
    res = '{0, 0, 0, 1'b0};
    if (it.kind && it.dof > DOF_RZ) begin
      res.bad = 1'b1;
      return;
    end
    if (it.kind && it.dof < DOF_RX) begin
      if (it.dof == DOF_TX) res.rx = 32'sd1 <<< FRAC_BITS;
      if (it.dof == DOF_TY) res.ry = 32'sd1 <<< FRAC_BITS;
      if (it.dof == DOF_TZ) res.rz = 32'sd1 <<< FRAC_BITS;
      return;
    end
    angle_trig(ang_x, sx, cx);
    angle_trig(ang_y, sy, cy);
    angle_trig(ang_z, sz, cz);
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    r00 = q30_mul(cy, cz);
    r01 = q30_mul(cy, sz);
    r02 = -sy;
    r10 = q30_mul(sxsy, cz) - q30_mul(cx, sz);
    r11 = q30_mul(sxsy, sz) + q30_mul(cx, cz);
    r12 = q30_mul(sx, cy);
    r20 = q30_mul(cxsy, cz) + q30_mul(sx, sz);
    r21 = q30_mul(cxsy, sz) - q30_mul(sx, cz);
    r22 = q30_mul(cx, cy);
    for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) m[i][j] = 0;
    q[0] = it.px; q[1] = it.py; q[2] = it.pz;
    if (!it.kind) begin
      m[0] = '{r00, r01, r02};
      m[1] = '{r10, r11, r12};
      m[2] = '{r20, r21, r22};
    end else begin
      for (int i = 0; i < 3; i++) q[i] = round_shift(q[i] * longint'(RAD_K), 32);
      if (it.dof == DOF_RX) begin
        m[1] = '{r20, r21, r22};
        m[2] = '{-r10, -r11, -r12};
      end else if (it.dof == DOF_RY) begin
        m[0] = '{-q30_mul(sy, cz), -q30_mul(sy, sz), -cy};
        m[1] = '{q30_mul(r12, cz), q30_mul(r12, sz), -sxsy};
        m[2] = '{q30_mul(r22, cz), q30_mul(r22, sz), -cxsy};
      end else begin
        m[0] = '{-r01, r00, 0};
        m[1] = '{-r11, r10, 0};
        m[2] = '{-r21, r20, 0};
      end
    end
    res.rx = row_dot(m[0][0], m[0][1], m[0][2], q[0], q[1], q[2]);
    res.ry = row_dot(m[1][0], m[1][1], m[1][2], q[0], q[1], q[2]);
    res.rz = row_dot(m[2][0], m[2][1], m[2][2], q[0], q[1], q[2]);
  endtask

  // Input driver: per-item random gap, then hold valid until transfer
  int in_gap = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pending_points.pop_front();
      in_gap = $urandom_range(0, 10);
      if (in_gap == 0 && pending_points.size() > 0 && driving) begin
        kind <= pending_points[0].kind;
        dof_index <= pending_points[0].dof;
        point_x <= pending_points[0].px;
        point_y <= pending_points[0].py;
        point_z <= pending_points[0].pz;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && driving && pending_points.size() > 0) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        in_valid <= 1'b1;
        kind <= pending_points[0].kind;
        dof_index <= pending_points[0].dof;
        point_x <= pending_points[0].px;
        point_y <= pending_points[0].py;
        point_z <= pending_points[0].pz;
      end
    end
  end

  // Predict on every accepted input transfer
  always @(posedge clk) begin
    point_result_t exp_r;
    point_item_t it;
    if (!rst && in_valid && in_ready) begin
      it = '{kind, dof_index, point_x, point_y, point_z};
      predict_point(it, exp_r);
      expected_results.push_back(exp_r);
      if (kind) n_deriv++;
    end
  end

  // Output monitor with per-result random stall
  int out_stall = 0;
  always @(posedge clk) begin
    point_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d bad=%0b", $time,
                   result_x, result_y, result_z, bad_dof);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result_x !== e.rx) begin
            $display("%0t: result_x expected %0d actual %0d", $time, e.rx, result_x);
            errors++;
          end
          if (result_y !== e.ry) begin
            $display("%0t: result_y expected %0d actual %0d", $time, e.ry, result_y);
            errors++;
          end
          if (result_z !== e.rz) begin
            $display("%0t: result_z expected %0d actual %0d", $time, e.rz, result_z);
            errors++;
          end
          if (bad_dof !== e.bad) begin
            $display("%0t: bad_dof expected %0b actual %0b", $time, e.bad, bad_dof);
            errors++;
          end
        end
        out_stall = $urandom_range(0, 10);
        out_ready <= (out_stall == 0);
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= (out_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle > CYCLE_LIMIT) begin
      $display("euler_rotate_point_and_jacobian_tb failed");
      $finish;
    end
  end

  task automatic write_angle(input logic [1:0] idx, input longint value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[ANG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ANGLE_X: ang_x = value;
      REG_ANGLE_Y: ang_y = value;
      REG_ANGLE_Z: ang_z = value;
      default: ;
    endcase
  endtask

  function automatic point_item_t rand_point();
    point_item_t it;
    int sel;
    it.kind = 1'($urandom_range(0, 1));
    it.dof = (it.kind && $urandom_range(0, 3) != 0) ? 3'($urandom_range(3, 5))
                                                     : 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 9);
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    if (sel < 6) begin
      // moderate magnitudes mostly
      it.px = it.px >>> $urandom_range(4, 16);
      it.py = it.py >>> $urandom_range(4, 16);
      it.pz = it.pz >>> $urandom_range(4, 16);
    end
    return it;
  endfunction

  // Wait for the pipeline to drain and settle
  task automatic drain();
    while (pending_points.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic longint rand_angle();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: return -longint'(DEG180);
      1: return longint'(DEG180);
      2: return longint'($urandom_range(0, 8)) * 45 * 65536 - 180 * 65536;
      default: return longint'($urandom_range(0, 2 * DEG180)) - longint'(DEG180);
    endcase
  endfunction

  longint ang_sets[6][3] = '{
    '{0, 0, 0},
    '{180 * 65536, -180 * 65536, 45 * 65536},
    '{30 * 65536, 60 * 65536, 90 * 65536},
    '{-11796480, 11796480, -1},
    '{2949121, -2949119, 135 * 65536 + 123},
    '{-90 * 65536, 270 * 65536 / 2, 1}
  };

  initial begin
    point_item_t it;
    logic signed [31:0] extremes[4] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd65536};
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Directed: every kind/dof with extreme points under the first two of six angle sets
    for (phase = 0; phase < 6; phase++) begin
      for (int r = 0; r < 3; r++) write_angle(r[1:0], ang_sets[phase][r]);
      if (phase < 2) begin
        for (int d = 0; d < 8; d++) begin
          it = '{1'b1, d[2:0], extremes[d % 4], extremes[(d + 1) % 4], extremes[(d + 2) % 4]};
          pending_points.push_back(it);
        end
        for (int e = 0; e < 4; e++) begin
          it = '{1'b0, e[2:0], extremes[e], extremes[(e + 3) % 4], extremes[(e + 1) % 4]};
          pending_points.push_back(it);
        end
      end
      for (int n = 0; n < 40; n++) pending_points.push_back(rand_point());
      driving = 1'b1;
      drain();
      driving = 1'b0;
    end
    // Random phases with fresh angle settings
    for (phase = 0; phase < 10; phase++) begin
      for (int r = 0; r < 3; r++)
        if (phase == 0 || $urandom_range(0, 2) != 0) write_angle(r[1:0], rand_angle());
      for (int n = 0; n < N_RANDOM / 10; n++) pending_points.push_back(rand_point());
      driving = 1'b1;
      drain();
      driving = 1'b0;
    end
    $display("Covered %0d results (%0d derivative items) over 16 angle settings.",
             n_results, n_deriv);
    if (errors == 0) begin
      $display("euler_rotate_point_and_jacobian_tb passed");
    end else begin
      $display("euler_rotate_point_and_jacobian_tb failed");
    end
    $finish;
  end
endmodule

>>> euler_rotate_point_and_jacobian.f
hw/rtl/ertj_pkg.sv
hw/rtl/ertj_div.sv
hw/rtl/ertj_trig.sv
hw/rtl/ertj_pipe.sv
hw/rtl/euler_rotate_point_and_jacobian.sv
tb/euler_rotate_point_and_jacobian_tb.sv
